// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain invariant checked on every clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/md5_pkg.sv
// md5 engine package: states, initial vector and round tables
`default_nettype none
package md5_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP_PRE,
    ST_COMP,
    ST_COMP_ADD,
    ST_PAD_HEAD,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    AFT_IDLE,
    AFT_HEAD,
    AFT_SPILL,
    AFT_DONE
  } after_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] PAD_BYTE = 32'h00000080;
  localparam logic [3:0] LEN_LO_WORD = 4'd14;
  localparam logic [3:0] LEN_HI_WORD = 4'd15;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] ii;
    logic [3:0] g;
    ii = i[3:0];
    unique case (i[5:4])
      2'd0: g = ii;
      2'd1: g = 4'(ii * 4'd5 + 4'd1);
      2'd2: g = 4'(ii * 4'd3 + 4'd5);
      2'd3: g = 4'(ii * 4'd7);
      default: g = ii;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// File: rtl/md5_hash_engine_top.sv
// md5 digest engine: byte intake, block buffer memory, round sequencer, padding
//
// Input channel (in_valid / in_stall): one item per byte. in_byte_valid marks
// in_data_byte as message data; in_last ends the message. A last item with
// in_byte_valid low ends the message without data, so empty messages work.
// Result channel (out_valid / out_stall): one item per message carrying the
// digest words a,b in out_digest_first and c,d in out_digest_second.
// A byte that neither fills the block nor ends the message leaves the
// engine idle and ready for the next item. The 64th byte of a block starts
// a compression: the intake, one read setup, 64 rounds at one per cycle, one
// chaining add; the round loop reads the 16x32 block memory one word ahead
// through its registered port. A last item adds padding writes, one or two
// compressions and a load of the result register.
// The block takes no item while it works on a block or on padding.
// A waiting result does not block the next message; only a finishing message
// waits, in its final state, until the previous result has been taken.
// Reset (rst_n low, synchronous) loads the initial vector, clears the byte
// count and block position and drops out_valid; the buffer is not cleared.
module md5_hash_engine_top #(
  parameter int LENGTH_COUNT_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_valid,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_digest_first,
  output logic [63:0]      out_digest_second
);
  import md5_pkg::*;

  `include "assert_macros.svh"

  localparam int LenPad = 61 - LENGTH_COUNT_BITS;

  state_t state_r, state_nxt;
  after_t after_r, after_nxt;
  logic [5:0] pos_r, pos_nxt;
  logic [LENGTH_COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [5:0] round_r, round_nxt;
  logic [3:0] pad_w_r, pad_w_nxt;
  logic len_ok_r, len_ok_nxt;
  logic [31:0] ha_r, hb_r, hc_r, hd_r;
  logic [31:0] ha_nxt, hb_nxt, hc_nxt, hd_nxt;
  logic [31:0] wa_r, wb_r, wc_r, wd_r;
  logic [31:0] wa_nxt, wb_nxt, wc_nxt, wd_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [63:0] out_first_r, out_first_nxt, out_second_r, out_second_nxt;

  logic [31:0] mem [16];
  logic mem_we;
  logic [3:0] mem_waddr;
  logic [31:0] mem_wdata;
  logic [3:0] mem_raddr;
  logic [31:0] mem_rdata_r;

  logic [31:0] f_val, t_val, rot_val;
  logic [63:0] rot_wide;
  logic [63:0] len_bits;
  logic [4:0] byte_shift;
  logic [31:0] head_word;

  assign len_bits = {{LenPad{1'b0}}, cnt_r, 3'b000};
  assign byte_shift = {pos_r[1:0], 3'b000};
  assign head_word = (pos_r[1:0] == 2'd0) ? PAD_BYTE : (acc_r | (PAD_BYTE << byte_shift));

  // one md5 round on the working words
  always_comb begin
    unique case (round_r[5:4])
      2'd0: f_val = (wb_r & wc_r) | (~wb_r & wd_r);
      2'd1: f_val = (wb_r & wd_r) | (wc_r & ~wd_r);
      2'd2: f_val = wb_r ^ wc_r ^ wd_r;
      2'd3: f_val = wc_r ^ (wb_r | ~wd_r);
      default: f_val = wb_r ^ wc_r ^ wd_r;
    endcase
    t_val = wa_r + f_val + round_const(round_r) + mem_rdata_r;
    rot_wide = {t_val, t_val} << rot_amount(round_r);
    rot_val = rot_wide[63:32];
  end

  always_comb begin
    state_nxt = state_r;
    after_nxt = after_r;
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    round_nxt = round_r;
    pad_w_nxt = pad_w_r;
    len_ok_nxt = len_ok_r;
    ha_nxt = ha_r; hb_nxt = hb_r; hc_nxt = hc_r; hd_nxt = hd_r;
    wa_nxt = wa_r; wb_nxt = wb_r; wc_nxt = wc_r; wd_nxt = wd_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_first_nxt = out_first_r;
    out_second_nxt = out_second_r;
    mem_we = 1'b0;
    mem_waddr = pos_r[5:2];
    mem_wdata = acc_r;
    mem_raddr = msg_index(6'd0);
    in_stall = (state_r != ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_byte_valid) begin
            acc_nxt = (pos_r[1:0] == 2'd0) ? {24'd0, in_data_byte}
                                           : (acc_r | ({24'd0, in_data_byte} << byte_shift));
            cnt_nxt = cnt_r + LENGTH_COUNT_BITS'(1);
            pos_nxt = pos_r + 6'd1;
            if (pos_r[1:0] == 2'd3) begin
              mem_we = 1'b1;
              mem_wdata = acc_nxt;
            end
            if (pos_r == 6'd63) begin
              state_nxt = ST_COMP_PRE;
              after_nxt = in_last ? AFT_HEAD : AFT_IDLE;
            end else if (in_last) begin
              state_nxt = ST_PAD_HEAD;
            end
          end else if (in_last) begin
            state_nxt = ST_PAD_HEAD;
          end
        end
      end
      ST_COMP_PRE: begin
        mem_raddr = msg_index(6'd0);
        round_nxt = 6'd0;
        wa_nxt = ha_r; wb_nxt = hb_r; wc_nxt = hc_r; wd_nxt = hd_r;
        state_nxt = ST_COMP;
      end
      ST_COMP: begin
        // address for the next round goes out while this round computes
        mem_raddr = msg_index(round_r + 6'd1);
        wa_nxt = wd_r;
        wd_nxt = wc_r;
        wc_nxt = wb_r;
        wb_nxt = wb_r + rot_val;
        round_nxt = round_r + 6'd1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_COMP_ADD;
        end
      end
      ST_COMP_ADD: begin
        ha_nxt = ha_r + wa_r;
        hb_nxt = hb_r + wb_r;
        hc_nxt = hc_r + wc_r;
        hd_nxt = hd_r + wd_r;
        unique case (after_r)
          AFT_IDLE: state_nxt = ST_IDLE;
          AFT_HEAD: state_nxt = ST_PAD_HEAD;
          AFT_SPILL: begin
            state_nxt = ST_PAD_ZERO;
            pad_w_nxt = 4'd0;
            len_ok_nxt = 1'b1;
          end
          AFT_DONE: state_nxt = ST_DONE;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_PAD_HEAD: begin
        mem_we = 1'b1;
        mem_waddr = pos_r[5:2];
        mem_wdata = head_word;
        len_ok_nxt = (pos_r[5:2] < LEN_LO_WORD);
        pad_w_nxt = pos_r[5:2] + 4'd1;
        if (pos_r[5:2] == LEN_HI_WORD) begin
          state_nxt = ST_COMP_PRE;
          after_nxt = AFT_SPILL;
        end else begin
          state_nxt = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        mem_we = 1'b1;
        mem_waddr = pad_w_r;
        if (pad_w_r == LEN_LO_WORD && len_ok_r) begin
          mem_wdata = len_bits[31:0];
          state_nxt = ST_PAD_LEN;
        end else begin
          mem_wdata = 32'd0;
          pad_w_nxt = pad_w_r + 4'd1;
          if (pad_w_r == LEN_HI_WORD) begin
            state_nxt = ST_COMP_PRE;
            after_nxt = AFT_SPILL;
          end
        end
      end
      ST_PAD_LEN: begin
        mem_we = 1'b1;
        mem_waddr = LEN_HI_WORD;
        mem_wdata = len_bits[63:32];
        state_nxt = ST_COMP_PRE;
        after_nxt = AFT_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_first_nxt = {hb_r, ha_r};
          out_second_nxt = {hd_r, hc_r};
          ha_nxt = IV_A; hb_nxt = IV_B; hc_nxt = IV_C; hd_nxt = IV_D;
          cnt_nxt = '0;
          pos_nxt = 6'd0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_r <= AFT_IDLE;
      pos_r <= 6'd0;
      cnt_r <= '0;
      round_r <= 6'd0;
      pad_w_r <= 4'd0;
      len_ok_r <= 1'b0;
      ha_r <= IV_A; hb_r <= IV_B; hc_r <= IV_C; hd_r <= IV_D;
      out_valid_r <= 1'b0;
    end else begin
      after_r <= after_nxt;
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
      round_r <= round_nxt;
      pad_w_r <= pad_w_nxt;
      len_ok_r <= len_ok_nxt;
      ha_r <= ha_nxt; hb_r <= hb_nxt; hc_r <= hc_nxt; hd_r <= hd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    wa_r <= wa_nxt; wb_r <= wb_nxt; wc_r <= wc_nxt; wd_r <= wd_nxt;
    out_first_r <= out_first_nxt;
    out_second_r <= out_second_nxt;
  end

  // block buffer; writes never share an edge with a round read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_digest_first = out_first_r;
  assign out_digest_second = out_second_r;

  `ASSERT_IMPL(a_result_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_DONE), "result raised outside done state")
  `ASSERT_IMPL(a_round_end, clk, rst_n, (state_r == ST_COMP && round_r == LAST_ROUND) |=> (state_r == ST_COMP_ADD), "round loop did not end after last round")
  `ASSERT_IMPL(a_restart_clean, clk, rst_n, (state_r == ST_DONE && state_nxt == ST_IDLE) |=> (cnt_r == '0 && pos_r == 6'd0 && ha_r == IV_A), "engine not reinitialized after digest")
  `ASSERT_NEVER(a_no_write_in_rounds, clk, rst_n, (state_r == ST_COMP || state_r == ST_COMP_PRE) && mem_we, "buffer written during compression")

endmodule
`default_nettype wire

// File: tb/sv/tb_md5_hash_engine_top.sv
// self-checking testbench for the md5 digest engine with a built-in digest predictor
`default_nettype none
module tb_md5_hash_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 250;
  localparam int PHASE_ITEMS = 420;

  localparam bit [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int ROT_TABLE [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  localparam int BOUNDARY_LENS [13] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128};

  typedef struct packed {
    logic [63:0] first;
    logic [63:0] second;
  } digest_t;

  class md5_digest_scoreboard;
    bit [31:0] chain [4];
    bit [31:0] blk [16];
    bit [31:0] byte_total;
    bit [5:0] pos;
    digest_t expected_digests [$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
      byte_total = 0;
      pos = 0;
    endfunction

    function void mix_block();
      bit [31:0] a, b, c, d, f, t;
      int g, s;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int i = 0; i < 64; i++) begin
        case (i >> 4)
          0: begin
            f = (b & c) | (~b & d);
            g = i;
          end
          1: begin
            f = (b & d) | (c & ~d);
            g = (5 * i + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            g = (3 * i + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            g = (7 * i) % 16;
          end
        endcase
        t = a + f + SINE_K[i] + blk[g];
        s = ROT_TABLE[((i >> 4) << 2) | (i & 3)];
        a = d;
        d = c;
        c = b;
        b = b + ((t << s) | (t >> (32 - s)));
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    function void pack_byte(bit [7:0] v);
      if (pos[1:0] == 2'd0) begin
        blk[pos[5:2]] = {24'd0, v};
      end else begin
        blk[pos[5:2]] |= {24'd0, v} << (8 * pos[1:0]);
      end
      pos++;
      if (pos == 6'd0) begin
        mix_block();
      end
    endfunction

    function void note_item(bit [7:0] data, bit byte_ok, bit lst);
      bit [63:0] bitlen;
      digest_t dg;
      if (byte_ok) begin
        pack_byte(data);
        byte_total++;
      end
      if (lst) begin
        pack_byte(8'h80);
        while (pos != 6'd56) pack_byte(8'h00);
        bitlen = {29'd0, byte_total, 3'b000};
        blk[14] = bitlen[31:0];
        blk[15] = bitlen[63:32];
        mix_block();
        dg.first = {chain[1], chain[0]};
        dg.second = {chain[3], chain[2]};
        expected_digests.push_back(dg);
        restart();
      end
    endfunction

    function void check_digest(logic [63:0] first, logic [63:0] second);
      digest_t dg;
      if (expected_digests.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected digest: first %h second %h", first, second);
        end
        mismatches++;
      end else begin
        dg = expected_digests.pop_front();
        if (first !== dg.first || second !== dg.second) begin
          if (mismatches < 10) begin
            $display("digest mismatch: expected first %h second %h, got first %h second %h",
                     dg.first, dg.second, first, second);
          end
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_digests.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic in_byte_valid = 1'b0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] out_digest_first;
  logic [63:0] out_digest_second;

  md5_digest_scoreboard digests;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  bit hold_pending = 1'b0;
  int hold_left = 0;
  int items_sent = 0;
  int cycle_count = 0;

  md5_hash_engine_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_byte_valid(in_byte_valid),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_digest_first(out_digest_first),
    .out_digest_second(out_digest_second)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && out_valid && !out_stall) begin
      digests.check_digest(out_digest_first, out_digest_second);
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stall, plus one long hold-off
  always @(negedge clk) begin
    if (hold_pending && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_pending = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_item(input logic [7:0] data, input bit byte_ok, input bit lst);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'($urandom_range(255));
      in_byte_valid <= 1'($urandom_range(1));
      in_last <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_byte_valid <= byte_ok;
    in_last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    digests.note_item(data, byte_ok, lst);
    if (byte_ok || lst) begin
      items_sent++;
    end
    @(negedge clk);
  endtask

  task automatic send_message(input int len);
    bit tail_last;
    logic [7:0] data;
    tail_last = (len != 0) && ($urandom_range(1) == 1);
    for (int k = 0; k < len; k++) begin
      // ignored filler item
      if ($urandom_range(99) < 5) begin
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      end
      data = ($urandom_range(9) == 0) ? 8'hff : 8'($urandom_range(255));
      send_item(data, 1'b1, tail_last && (k == len - 1));
    end
    if (!tail_last) begin
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  initial begin
    int target;
    int len;
    int pick;
    digests = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty message, single bytes, bytes then a bare last, a two-byte message, two empty messages
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'haa, 1'b1, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 52;
          stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct = 52;
        end
        default: begin
          sender_idle_pct = 21;
          stall_pct = 21;
        end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          len = BOUNDARY_LENS[$urandom_range(12)];
        end else if (pick < 85) begin
          len = $urandom_range(60);
        end else begin
          len = $urandom_range(200, 61);
        end
        send_message(len);
      end
    end

    // long receiver hold-off while messages keep coming
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_pending = 1'b1;
    repeat (8) send_message($urandom_range(20));
    in_valid <= 1'b0;

    while (digests.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (digests.mismatches == 0 && digests.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
